// ===== rtl/v3a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types and codes for the 3D vector arithmetic unit: opcodes, the
// request and response beats, and the sideband carried down the pipelines.
// ----------------------------------------------------------------------------
package v3a_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DOT   = 3'd3;
    localparam logic [2:0] OP_CROSS = 3'd4;
    localparam logic [2:0] OP_MAG   = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;
    localparam logic [2:0] OP_HDIV  = 3'd7;

    typedef struct packed {
        logic [2:0]                  op;
        logic signed [WORD_BITS-1:0] ax;
        logic signed [WORD_BITS-1:0] ay;
        logic signed [WORD_BITS-1:0] az;
        logic signed [WORD_BITS-1:0] aw;
        logic signed [WORD_BITS-1:0] bx;
        logic signed [WORD_BITS-1:0] by;
        logic signed [WORD_BITS-1:0] bz;
        logic signed [WORD_BITS-1:0] scale;
    } v3a_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] rx;
        logic signed [WORD_BITS-1:0] ry;
        logic signed [WORD_BITS-1:0] rz;
        logic signed [WORD_BITS-1:0] scalar_out;
        logic                        fault;
    } v3a_out_t;

    // operand context carried through the product stages
    typedef struct packed {
        logic [2:0]                 op;
        logic [2:0][WORD_BITS-1:0]  amag;
        logic [2:0]                 asg;
        logic [WORD_BITS-1:0]       wmag;
        logic                       wsg;
    } v3a_ctx_t;

    // sideband through the square root pipe
    typedef struct packed {
        v3a_ctx_t                   ctx;
        logic [3:0][WORD_BITS-1:0]  res;
        logic                       flt;
    } v3a_sq_side_t;

    // sideband through the divider pipe
    typedef struct packed {
        logic [2:0]                 op;
        logic [2:0]                 asg;
        logic                       dsg;
        logic                       wzero;
        logic [2:0]                 ovf;
        logic [3:0][WORD_BITS-1:0]  res;
        logic                       flt;
    } v3a_dv_side_t;

endpackage
`default_nettype wire

// ===== rtl/v3a_sqrt_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_sqrt_pipe
// Digit-by-digit integer square root, one root bit per stage. Gives the
// floor root and the remainder; sideband rides along with each beat.
// ----------------------------------------------------------------------------
module v3a_sqrt_pipe
    import v3a_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2*WORD_BITS-1:0]   radicand,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [WORD_BITS-1:0]     root,
    output logic [WORD_BITS+1:0]     rem,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int W  = WORD_BITS;
    localparam int RW = W + 2;

    logic [W-1:0]      vld_reg;
    logic [2*W-1:0]    rad_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [RW-1:0]     rem_reg  [W];
    logic [SIDE_W-1:0] side_reg [W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[W-2:0], in_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stg
            logic [2*W-1:0]    rad_prev;
            logic [W-1:0]      root_prev;
            logic [RW-1:0]     rem_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [RW+1:0]     trial;
            logic [RW+1:0]     tst;
            logic              ge;

            if (k == 0)
            begin : g_head
                assign rad_prev  = radicand;
                assign root_prev = '0;
                assign rem_prev  = '0;
                assign side_prev = in_side;
            end
            else
            begin : g_tail
                assign rad_prev  = rad_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            assign trial = {rem_prev, rad_prev[2*W-1 -: 2]};
            assign tst   = {2'b00, root_prev, 2'b01};
            assign ge    = trial >= tst;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= {rad_prev[2*W-3:0], 2'b00};
                    root_reg[k] <= {root_prev[W-2:0], ge};
                    rem_reg[k]  <= ge ? RW'(trial - tst) : trial[RW-1:0];
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign root      = root_reg[W-1];
    assign rem       = rem_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule
`default_nettype wire

// ===== rtl/v3a_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3a_div_pipe
// Three-lane restoring divider sharing one divisor, one quotient bit per
// stage. Numerator top must already be below the divisor (no overflow).
// ----------------------------------------------------------------------------
module v3a_div_pipe
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [WORD_BITS:0]                     dvsr,
    input  logic [2:0][WORD_BITS+FRAC_BITS:0]      num,
    input  logic [SIDE_W-1:0]                      in_side,
    output logic                                   out_valid,
    output logic [2:0][WORD_BITS-1:0]              quo,
    output logic [SIDE_W-1:0]                      out_side
);

    localparam int W  = WORD_BITS;
    localparam int DW = W + 1;
    localparam int NB = W + FRAC_BITS + 1;

    logic [W-1:0]           vld_reg;
    logic [2:0][DW-1:0]     rem_reg  [W];
    logic [2:0][W-1:0]      num_reg  [W];
    logic [2:0][W-1:0]      quo_reg  [W];
    logic [DW-1:0]          d_reg    [W];
    logic [SIDE_W-1:0]      side_reg [W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[W-2:0], in_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_stg
            logic [2:0][DW-1:0] r_prev;
            logic [2:0][W-1:0]  n_prev;
            logic [2:0][W-1:0]  q_prev;
            logic [DW-1:0]      d_prev;
            logic [SIDE_W-1:0]  s_prev;
            logic [2:0][DW-1:0] r_nxt;
            logic [2:0][W-1:0]  n_nxt;
            logic [2:0][W-1:0]  q_nxt;

            if (k == 0)
            begin : g_head
                always_comb
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        r_prev[l] = {{(DW-FRAC_BITS-1){1'b0}}, num[l][NB-1:W]};
                        n_prev[l] = num[l][W-1:0];
                    end
                end
                assign q_prev = '0;
                assign d_prev = dvsr;
                assign s_prev = in_side;
            end
            else
            begin : g_tail
                assign r_prev = rem_reg[k-1];
                assign n_prev = num_reg[k-1];
                assign q_prev = quo_reg[k-1];
                assign d_prev = d_reg[k-1];
                assign s_prev = side_reg[k-1];
            end

            always_comb
            begin : c_step
                logic [DW:0] trial;
                for (int l = 0; l < 3; l++)
                begin
                    trial    = {r_prev[l], n_prev[l][W-1]};
                    n_nxt[l] = {n_prev[l][W-2:0], 1'b0};
                    if (trial >= {1'b0, d_prev})
                    begin
                        r_nxt[l] = DW'(trial - {1'b0, d_prev});
                        q_nxt[l] = {q_prev[l][W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_nxt[l] = trial[DW-1:0];
                        q_nxt[l] = {q_prev[l][W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= r_nxt;
                    num_reg[k]  <= n_nxt;
                    quo_reg[k]  <= q_nxt;
                    d_reg[k]    <= d_prev;
                    side_reg[k] <= s_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[W-1];
    assign quo       = quo_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule
`default_nettype wire

// ===== rtl/vector3_arith_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_arith_unit_top
// Pipelined Q16.16 vector unit: add, sub, scale, dot, cross, magnitude,
// normalize and homogeneous divide, with saturation and a fault flag.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not held; every beat
// passes through the bit-per-stage square root and divider pipes to keep results in order.
// The whole pipe holds while a result waits at the output.
// Reset clears only the valid bits; data registers are not reset.
module vector3_arith_unit_top
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  v3a_in_t  req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output v3a_out_t rsp_data
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SB = 2 * W + 3;
    localparam int RW = W + 2;
    localparam int DW = W + 1;
    localparam int NB = W + F + 1;
    localparam int CW = 2 * W + 1;

    localparam logic [5:0][1:0] CR_A = {2'd1, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1};
    localparam logic [5:0][1:0] CR_B = {2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    localparam logic [SB-1:0] HALF    = SB'(1) << (F - 1);
    localparam logic [SB-1:0] LIM_NEG = SB'(1) << (W - 1);
    localparam logic [SB-1:0] LIM_POS = LIM_NEG - SB'(1);

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        abs_w = v[W-1] ? -v : v;
    endfunction

    logic en;
    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    // ---------------- stage 1: sign/magnitude, lane operand select ----------
    logic [2:0][W-1:0] in_a, in_b;
    logic [2:0][W-1:0] c1_bmag;
    logic [2:0]        c1_bsg;
    logic [W-1:0]      c1_smag;
    logic              c1_ssg;
    logic [5:0][W-1:0] c1_lx, c1_ly;
    logic [5:0]        c1_ls;
    logic [2:0][W:0]   c1_as;
    v3a_ctx_t          c1_ctx;

    assign in_a = {req_data.az, req_data.ay, req_data.ax};
    assign in_b = {req_data.bz, req_data.by, req_data.bx};

    always_comb
    begin
        c1_ctx.op   = req_data.op;
        c1_ctx.wmag = abs_w(req_data.aw);
        c1_ctx.wsg  = req_data.aw[W-1];
        c1_smag     = abs_w(req_data.scale);
        c1_ssg      = req_data.scale[W-1];
        for (int i = 0; i < 3; i++)
        begin
            c1_ctx.amag[i] = abs_w(in_a[i]);
            c1_ctx.asg[i]  = in_a[i][W-1];
            c1_bmag[i]     = abs_w(in_b[i]);
            c1_bsg[i]      = in_b[i][W-1];
            if (req_data.op == OP_SUB)
                c1_as[i] = {in_a[i][W-1], in_a[i]} - {in_b[i][W-1], in_b[i]};
            else
                c1_as[i] = {in_a[i][W-1], in_a[i]} + {in_b[i][W-1], in_b[i]};
        end
        c1_lx = '0;
        c1_ly = '0;
        c1_ls = '0;
        case (req_data.op) inside
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c1_lx[i] = c1_ctx.amag[i];
                    c1_ly[i] = c1_smag;
                    c1_ls[i] = c1_ctx.asg[i] ^ c1_ssg;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c1_lx[i] = c1_ctx.amag[i];
                    c1_ly[i] = c1_bmag[i];
                    c1_ls[i] = c1_ctx.asg[i] ^ c1_bsg[i];
                end
            end
            OP_CROSS:
            begin
                for (int k = 0; k < 6; k++)
                begin
                    c1_lx[k] = c1_ctx.amag[CR_A[k]];
                    c1_ly[k] = c1_bmag[CR_B[k]];
                    c1_ls[k] = c1_ctx.asg[CR_A[k]] ^ c1_bsg[CR_B[k]];
                end
            end
            OP_MAG, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c1_lx[i] = c1_ctx.amag[i];
                    c1_ly[i] = c1_ctx.amag[i];
                end
            end
            default: ;
        endcase
    end

    logic              s1_vld_reg;
    v3a_ctx_t          s1_ctx_reg;
    logic [5:0][W-1:0] s1_lx_reg, s1_ly_reg;
    logic [5:0]        s1_ls_reg;
    logic [2:0][W:0]   s1_as_reg;

    // ---------------- stage 2: products ------------------------------------
    logic               s2_vld_reg;
    v3a_ctx_t           s2_ctx_reg;
    logic [5:0][PW-1:0] s2_p_reg;
    logic [5:0]         s2_ls_reg;
    logic [2:0][W:0]    s2_as_reg;

    // ---------------- stage 3: signed combine -------------------------------
    logic [5:0][PW:0]   c3_ps;
    logic [5:0][SB-1:0] c3_px;
    logic [3:0][SB-1:0] c3_u;
    logic [PW-1:0]      c3_sum;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            c3_ps[k] = s2_ls_reg[k] ? -{1'b0, s2_p_reg[k]} : {1'b0, s2_p_reg[k]};
            c3_px[k] = {{2{c3_ps[k][PW]}}, c3_ps[k]};
        end
        c3_sum = s2_p_reg[0] + s2_p_reg[1] + s2_p_reg[2];
        c3_u   = '0;
        case (s2_ctx_reg.op) inside
            OP_ADD, OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    c3_u[i] = {{(SB-W-1){s2_as_reg[i][W]}}, s2_as_reg[i]} << F;
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    c3_u[i] = c3_px[i];
            end
            OP_DOT:   c3_u[3] = c3_px[0] + c3_px[1] + c3_px[2];
            OP_CROSS:
            begin
                c3_u[0] = c3_px[0] - c3_px[1];
                c3_u[1] = c3_px[2] - c3_px[3];
                c3_u[2] = c3_px[4] - c3_px[5];
            end
            default: ;
        endcase
    end

    logic               s3_vld_reg;
    v3a_ctx_t           s3_ctx_reg;
    logic [3:0][SB-1:0] s3_u_reg;
    logic [PW-1:0]      s3_sum_reg;

    // ---------------- stage 4: magnitude ------------------------------------
    logic               s4_vld_reg;
    v3a_ctx_t           s4_ctx_reg;
    logic [3:0][SB-1:0] s4_um_reg;
    logic [3:0]         s4_usg_reg;
    logic [PW-1:0]      s4_sum_reg;

    // ---------------- stage 5: round and saturate ---------------------------
    v3a_sq_side_t c5_side;

    always_comb
    begin : c_round
        logic [SB-1:0] sh;
        logic [SB-1:0] lim;
        logic [SB-1:0] m;
        logic          sat;
        c5_side.ctx = s4_ctx_reg;
        c5_side.flt = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            sh  = (s4_um_reg[k] + HALF) >> F;
            lim = s4_usg_reg[k] ? LIM_NEG : LIM_POS;
            sat = sh > lim;
            m   = sat ? lim : sh;
            c5_side.res[k] = s4_usg_reg[k] ? -m[W-1:0] : m[W-1:0];
            c5_side.flt    = c5_side.flt | sat;
        end
    end

    logic         s5_vld_reg;
    v3a_sq_side_t s5_side_reg;
    logic [PW-1:0] s5_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= req_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg <= c1_ctx;
            s1_lx_reg  <= c1_lx;
            s1_ly_reg  <= c1_ly;
            s1_ls_reg  <= c1_ls;
            s1_as_reg  <= c1_as;

            s2_ctx_reg <= s1_ctx_reg;
            for (int k = 0; k < 6; k++)
                s2_p_reg[k] <= s1_lx_reg[k] * s1_ly_reg[k];
            s2_ls_reg  <= s1_ls_reg;
            s2_as_reg  <= s1_as_reg;

            s3_ctx_reg <= s2_ctx_reg;
            s3_u_reg   <= c3_u;
            s3_sum_reg <= c3_sum;

            s4_ctx_reg <= s3_ctx_reg;
            for (int k = 0; k < 4; k++)
            begin
                s4_um_reg[k]  <= s3_u_reg[k][SB-1] ? -s3_u_reg[k] : s3_u_reg[k];
                s4_usg_reg[k] <= s3_u_reg[k][SB-1];
            end
            s4_sum_reg <= s3_sum_reg;

            s5_side_reg <= c5_side;
            s5_sum_reg  <= s4_sum_reg;
        end
    end

    // ---------------- square root -------------------------------------------
    logic                             sq_vld;
    logic [W-1:0]                     sq_root;
    logic [RW-1:0]                    sq_rem;
    logic [$bits(v3a_sq_side_t)-1:0]  sq_side_raw;
    v3a_sq_side_t                     sq_side;

    v3a_sqrt_pipe #(
        .SIDE_W ($bits(v3a_sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .radicand  (s5_sum_reg),
        .in_side   (s5_side_reg),
        .out_valid (sq_vld),
        .root      (sq_root),
        .rem       (sq_rem),
        .out_side  (sq_side_raw)
    );

    assign sq_side = v3a_sq_side_t'(sq_side_raw);

    // ---------------- R1: round root, pick divisor --------------------------
    logic [DW-1:0] c6_mag;
    logic          c6_sat;
    logic [DW-1:0] c6_d;
    v3a_dv_side_t  c6_side;

    always_comb
    begin
        c6_mag = {1'b0, sq_root} + {{W{1'b0}}, (sq_rem > {2'b00, sq_root})};
        c6_sat = c6_mag > {2'b00, {(W-1){1'b1}}};
        c6_side.op    = sq_side.ctx.op;
        c6_side.asg   = sq_side.ctx.asg;
        c6_side.dsg   = (sq_side.ctx.op == OP_HDIV) && sq_side.ctx.wsg;
        c6_side.wzero = sq_side.ctx.wmag == '0;
        c6_side.ovf   = '0;
        c6_side.res   = sq_side.res;
        c6_side.flt   = sq_side.flt;
        case (sq_side.ctx.op)
            OP_NORM: c6_d = (c6_mag == '0) ? (DW'(1) << F) : c6_mag;
            OP_HDIV: c6_d = {1'b0, sq_side.ctx.wmag};
            default: c6_d = DW'(1);
        endcase
        if (sq_side.ctx.op == OP_MAG)
        begin
            c6_side.res[3] = c6_sat ? {1'b0, {(W-1){1'b1}}} : c6_mag[W-1:0];
            c6_side.flt    = c6_sat;
        end
        if (sq_side.ctx.op == OP_HDIV && c6_side.wzero)
            c6_side.flt = 1'b1;
    end

    logic              r1_vld_reg;
    logic [DW-1:0]     r1_d_reg;
    logic [2:0][W-1:0] r1_amag_reg;
    v3a_dv_side_t      r1_side_reg;

    // ---------------- R2: rounded dividend, overflow check ------------------
    logic [2:0][NB-1:0] c7_num;
    v3a_dv_side_t       c7_side;

    always_comb
    begin
        c7_side = r1_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            c7_num[i]      = (NB'(r1_amag_reg[i]) << F) + NB'(r1_d_reg >> 1);
            c7_side.ovf[i] = CW'(c7_num[i]) >= {r1_d_reg, {W{1'b0}}};
        end
    end

    logic               r2_vld_reg;
    logic [DW-1:0]      r2_d_reg;
    logic [2:0][NB-1:0] r2_num_reg;
    v3a_dv_side_t       r2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_vld_reg <= sq_vld;
            r2_vld_reg <= r1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_d_reg    <= c6_d;
            r1_amag_reg <= sq_side.ctx.amag;
            r1_side_reg <= c6_side;
            r2_d_reg    <= r1_d_reg;
            r2_num_reg  <= c7_num;
            r2_side_reg <= c7_side;
        end
    end

    // ---------------- divider -----------------------------------------------
    logic                             dv_vld;
    logic [2:0][W-1:0]                dv_quo;
    logic [$bits(v3a_dv_side_t)-1:0]  dv_side_raw;
    v3a_dv_side_t                     dv_side;

    v3a_div_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(v3a_dv_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r2_vld_reg),
        .dvsr      (r2_d_reg),
        .num       (r2_num_reg),
        .in_side   (r2_side_reg),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .out_side  (dv_side_raw)
    );

    assign dv_side = v3a_dv_side_t'(dv_side_raw);

    // ---------------- final: sign and saturate quotients --------------------
    v3a_out_t c8_out;

    always_comb
    begin : c_final
        logic [3:0][W-1:0] res;
        logic              flt;
        logic              sg;
        logic              sat;
        logic [W-1:0]      lim;
        logic [W-1:0]      m;
        res = dv_side.res;
        flt = dv_side.flt;
        for (int i = 0; i < 3; i++)
        begin
            sg  = dv_side.asg[i] ^ dv_side.dsg;
            lim = sg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            sat = dv_side.ovf[i] || (dv_quo[i] > lim);
            m   = sat ? lim : dv_quo[i];
            if (dv_side.op == OP_NORM || (dv_side.op == OP_HDIV && !dv_side.wzero))
            begin
                res[i] = sg ? -m : m;
                flt    = flt | sat;
            end
        end
        c8_out.rx         = res[0];
        c8_out.ry         = res[1];
        c8_out.rz         = res[2];
        c8_out.scalar_out = res[3];
        c8_out.fault      = flt;
    end

    logic     rsp_vld_reg;
    v3a_out_t rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_data_reg <= c8_out;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_data_reg;

    // ---------------- assertions --------------------------------------------
    a_norm_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
        (r1_vld_reg && r1_side_reg.op == OP_NORM) |-> (r1_d_reg != '0))
        else $error("normalize divisor is zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(s1_vld_reg) && $stable(r2_vld_reg)))
        else $error("pipe moved during stall");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld |-> (sq_rem <= {1'b0, sq_root, 1'b0}))
        else $error("square root remainder out of range");

endmodule
`default_nettype wire
